// ----- rtl/core/swu_pkg.sv -----
// Shared types, constants and helper functions of the swish activation unit.
`timescale 1ns / 1ps

package swu_pkg;

  // Fixed-point format of samples and gradients
  localparam int unsigned FRAC_BITS = 12;

  // log2(e) in Q.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

  // One and three in the sample format
  localparam logic signed [17:0] ONE_FX = 18'sd1 <<< FRAC_BITS;
  localparam logic signed [17:0] THREE_FX = 18'sd3 <<< FRAC_BITS;

  // ceil(2^19 / 3): exact floor division by three for operands below 2^19
  localparam logic [17:0] RECIP3 = 18'd174763;
  localparam int unsigned RECIP3_SHIFT = 19;

  // Register map
  localparam logic ADDR_MODE = 1'b0;

  typedef enum logic [1:0] {
    MODE_SILU        = 2'd0,
    MODE_HSWISH      = 2'd1,
    MODE_SILU_GRAD   = 2'd2,
    MODE_HSWISH_GRAD = 2'd3
  } swu_mode_e;

  // Fields that travel alongside the datapath
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] dy;
    logic               last;
  } swu_side_t;

  // Integer square root, used only to build constant tables
  function automatic logic [63:0] swu_isqrt(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-idx) in Q0.30, built by repeated square roots
  function automatic logic [30:0] swu_tab(input int unsigned idx);
    logic [63:0] t;
    t = 64'd1 << 29;
    for (int unsigned j = 1; j <= 30; j++) begin
      if (j <= idx) begin
        t = swu_isqrt(t << 30);
      end
    end
    return t[30:0];
  endfunction

  // Arithmetic shift right with rounding to nearest, ties away from zero
  function automatic logic signed [71:0] swu_rnd_shr(input logic signed [71:0] v,
                                                     input int unsigned sh);
    logic signed [71:0] half;
    logic signed [71:0] adj;
    half = 72'sd1 <<< (sh - 1);
    if (v[71]) begin
      adj = v + half - 72'sd1;
    end else begin
      adj = v + half;
    end
    return adj >>> sh;
  endfunction

endpackage

// ----- rtl/core/swish_activation_unit_top.sv -----
// Top level of the swish activation unit: register port, gradient datapath and output stage.
`timescale 1ns / 1ps

// Element-wise SiLU / hard swish unit and their gradients on signed Q4.12 samples.
// One element is taken every clock cycle unless the output is held. The sigmoid pipeline
// has 30 exp2 product stages and 31 divider stages, and the top level adds
// 6 product and rounding stages. The whole pipeline holds while a finished
// result waits on out_ready_i, so in_ready_o follows the output stage. The mode
// register sits at byte address 0 and must only be written while no element is in flight.

module swish_activation_unit_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] x_in_i,
  input  logic signed [15:0] grad_in_i,
  input  logic               last_in_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] result_o,
  output logic               clipped_o,
  output logic               last_out_o
);
  import swu_pkg::*;

  // Mode register
  swu_mode_e mode_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_MODE) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SILU;
    end else if (psel && penable && pwrite && (paddr[2] == ADDR_MODE)) begin
      mode_q <= swu_mode_e'(pwdata[1:0]);
    end
  end

  // Global advance: hold every stage while the output waits
  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  swu_side_t side_in;
  assign side_in = '{x: x_in_i, dy: grad_in_i, last: last_in_i};

  logic        sg_vld;
  swu_side_t   sg_side;
  logic [30:0] sg_sig;

  swu_sigmoid u_sigmoid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .side_i  (side_in),
    .valid_o (sg_vld),
    .side_o  (sg_side),
    .sig_o   (sg_sig)
  );

  // P1: x*s and the hard swish product
  logic signed [17:0] h_mul;
  logic signed [15:0] h_sel;
  logic               p1_vld_q;
  swu_side_t          p1_side_q;
  logic [30:0]        p1_sig_q;
  logic signed [47:0] p1_m0_q;
  logic signed [33:0] p1_hp_q;

  assign h_sel = (mode_q == MODE_HSWISH_GRAD) ? sg_side.dy : sg_side.x;
  assign h_mul = (mode_q == MODE_HSWISH_GRAD) ? ((18'(sg_side.x) <<< 1) + THREE_FX)
                                              : (18'(sg_side.x) + THREE_FX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= sg_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_side_q <= sg_side;
      p1_sig_q  <= sg_sig;
      p1_m0_q   <= 48'(sg_side.x) * 48'($signed({1'b0, sg_sig}));
      p1_hp_q   <= 34'(h_sel) * 34'(h_mul);
    end
  end

  // P2: round SiLU, form the gradient term q, scale the hard swish product
  logic signed [48:0] q_full;
  logic signed [71:0] v0_r;
  logic signed [71:0] q_r;
  logic [33:0]        h_abs;
  logic [33:0]        h_n;
  logic               p2_vld_q;
  swu_side_t          p2_side_q;
  logic [30:0]        p2_sig_q;
  logic signed [17:0] p2_v0_q;
  logic signed [34:0] p2_q_q;
  logic [17:0]        p2_hn_q;
  logic               p2_hneg_q;

  assign q_full = ((49'(18'(p1_side_q.x) + ONE_FX)) <<< 30) - 49'(p1_m0_q);
  assign v0_r   = swu_rnd_shr(72'(p1_m0_q), 30);
  assign q_r    = swu_rnd_shr(72'(q_full), 14);
  assign h_abs  = p1_hp_q[33] ? 34'(-p1_hp_q) : 34'(p1_hp_q);
  assign h_n    = (h_abs + 34'(THREE_FX)) >> (FRAC_BITS + 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_side_q <= p1_side_q;
      p2_sig_q  <= p1_sig_q;
      p2_v0_q   <= v0_r[17:0];
      p2_q_q    <= q_r[34:0];
      p2_hn_q   <= h_n[17:0];
      p2_hneg_q <= p1_hp_q[33];
    end
  end

  // P3: s*q and divide the hard swish term by three
  logic [35:0]        h_recip;
  logic               p3_vld_q;
  swu_side_t          p3_side_q;
  logic signed [17:0] p3_v0_q;
  logic signed [66:0] p3_tp_q;
  logic [16:0]        p3_hq_q;
  logic               p3_hneg_q;

  assign h_recip = (36'(p2_hn_q) * 36'(RECIP3)) >> RECIP3_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else if (en) begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_side_q <= p2_side_q;
      p3_v0_q   <= p2_v0_q;
      p3_tp_q   <= 67'($signed({1'b0, p2_sig_q})) * 67'(p2_q_q);
      p3_hq_q   <= h_recip[16:0];
      p3_hneg_q <= p2_hneg_q;
    end
  end

  // P4: round t, restore the hard swish sign
  logic signed [71:0] t_r;
  logic               p4_vld_q;
  swu_side_t          p4_side_q;
  logic signed [17:0] p4_v0_q;
  logic signed [36:0] p4_t_q;
  logic signed [17:0] p4_hv_q;

  assign t_r = swu_rnd_shr(72'(p3_tp_q), 30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q <= 1'b0;
    end else if (en) begin
      p4_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_side_q <= p3_side_q;
      p4_v0_q   <= p3_v0_q;
      p4_t_q    <= t_r[36:0];
      p4_hv_q   <= p3_hneg_q ? -$signed({1'b0, p3_hq_q}) : $signed({1'b0, p3_hq_q});
    end
  end

  // P5: dy*t
  logic               p5_vld_q;
  swu_side_t          p5_side_q;
  logic signed [17:0] p5_v0_q;
  logic signed [52:0] p5_v2p_q;
  logic signed [17:0] p5_hv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_vld_q <= 1'b0;
    end else if (en) begin
      p5_vld_q <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_side_q <= p4_side_q;
      p5_v0_q   <= p4_v0_q;
      p5_v2p_q  <= 53'(p4_side_q.dy) * 53'(p4_t_q);
      p5_hv_q   <= p4_hv_q;
    end
  end

  // Output stage: pick by mode, saturate, hold until taken
  logic signed [71:0] v2_r;
  logic signed [39:0] v_sel;
  logic signed [15:0] res_d;
  logic               clip_d;

  assign v2_r = swu_rnd_shr(72'(p5_v2p_q), FRAC_BITS + 16);

  always_comb begin
    unique case (mode_q)
      MODE_SILU: begin
        v_sel = 40'(p5_v0_q);
      end
      MODE_HSWISH: begin
        if (p5_side_q.x <= -THREE_FX) begin
          v_sel = '0;
        end else if (p5_side_q.x >= THREE_FX) begin
          v_sel = 40'(p5_side_q.x);
        end else begin
          v_sel = 40'(p5_hv_q);
        end
      end
      MODE_SILU_GRAD: begin
        v_sel = v2_r[39:0];
      end
      default: begin
        if (p5_side_q.x < -THREE_FX) begin
          v_sel = '0;
        end else if (p5_side_q.x < THREE_FX) begin
          v_sel = 40'(p5_hv_q);
        end else begin
          v_sel = 40'(p5_side_q.dy);
        end
      end
    endcase
  end

  always_comb begin
    if (v_sel > 40'sd32767) begin
      res_d  = 16'sh7fff;
      clip_d = 1'b1;
    end else if (v_sel < -40'sd32768) begin
      res_d  = -16'sh8000;
      clip_d = 1'b1;
    end else begin
      res_d  = v_sel[15:0];
      clip_d = 1'b0;
    end
  end

  logic signed [15:0] result_q;
  logic               clipped_q;
  logic               last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= p5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q  <= res_d;
      clipped_q <= clip_d;
      last_q    <= p5_side_q.last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = result_q;
  assign clipped_o   = clipped_q;
  assign last_out_o  = last_q;

endmodule

// ----- rtl/core/swu_sigmoid.sv -----
// Pipelined sigmoid in unsigned Q1.30: exp2 by bit-wise products, then bit-serial reciprocal.
`timescale 1ns / 1ps

module swu_sigmoid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  swu_pkg::swu_side_t  side_i,
  output logic                valid_o,
  output swu_pkg::swu_side_t  side_o,
  output logic [30:0]         sig_o
);
  import swu_pkg::*;

  localparam int unsigned EXP_N = 30;
  localparam int unsigned DIV_N = 31;

  // Stage A: |x| times log2(e)
  logic [15:0] abs_x;
  logic        a_vld_q;
  swu_side_t   a_side_q;
  logic [46:0] a_prod_q;

  assign abs_x = side_i.x[15] ? 16'(-side_i.x) : 16'(side_i.x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_side_q <= side_i;
      a_prod_q <= 47'(abs_x) * 47'(LOG2E_Q30);
    end
  end

  // Stage B and exp chain: element 0 holds z split into integer and fraction
  logic        ex_vld_q  [EXP_N+1];
  swu_side_t   ex_side_q [EXP_N+1];
  logic [16:0] ex_k_q    [EXP_N+1];
  logic [29:0] ex_f_q    [EXP_N+1];
  logic [30:0] ex_p_q    [EXP_N+1];
  logic [46:0] z_d;

  assign z_d = (a_prod_q + (47'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      ex_vld_q[0] <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_side_q[0] <= a_side_q;
      ex_k_q[0]    <= z_d[46:30];
      ex_f_q[0]    <= z_d[29:0];
      ex_p_q[0]    <= ONE_Q30;
    end
  end

  // One fraction bit per stage: multiply by 2^(-2^-i) where the bit is set
  for (genvar i = 1; i <= EXP_N; i++) begin : g_exp
    localparam logic [30:0] TV = swu_tab(i);
    logic [61:0] prod;
    logic [61:0] rnd;

    assign prod = 62'(ex_p_q[i-1]) * 62'(TV);
    assign rnd  = (prod + (62'd1 << 29)) >> 30;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ex_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        ex_vld_q[i] <= ex_vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ex_side_q[i] <= ex_side_q[i-1];
        ex_k_q[i]    <= ex_k_q[i-1];
        ex_f_q[i]    <= ex_f_q[i-1];
        ex_p_q[i]    <= ex_f_q[i-1][EXP_N-i] ? rnd[30:0] : ex_p_q[i-1];
      end
    end
  end

  // Stage E: scale by 2^-k with rounding, form the divisor 1 + e
  logic        dv_vld_q  [DIV_N+1];
  swu_side_t   dv_side_q [DIV_N+1];
  logic [31:0] dv_rem_q  [DIV_N+1];
  logic [30:0] dv_quo_q  [DIV_N+1];
  logic [31:0] dv_d_q    [DIV_N+1];
  logic [5:0]  k6;
  logic [31:0] e_sum;
  logic [31:0] e_val;
  logic [31:0] d_d;

  assign k6    = ex_k_q[EXP_N][5:0];
  assign e_sum = {1'b0, ex_p_q[EXP_N]} + ((k6 == 6'd0) ? 32'd0 : (32'd1 << (k6 - 6'd1)));
  assign e_val = (ex_k_q[EXP_N] > 17'd40) ? 32'd0 : (e_sum >> k6);
  assign d_d   = 32'(ONE_Q30) + e_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_vld_q[0] <= ex_vld_q[EXP_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_side_q[0] <= ex_side_q[EXP_N];
      dv_rem_q[0]  <= 32'd1 << 29;
      dv_quo_q[0]  <= '0;
      dv_d_q[0]    <= d_d;
    end
  end

  // Restoring division of 2^60 + d/2 by d, one quotient bit per stage
  for (genvar g = 1; g <= DIV_N; g++) begin : g_div
    localparam int unsigned J = DIV_N - g;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_n;

    assign rem_sh = {dv_rem_q[g-1], dv_d_q[g-1][J+1]};
    assign ge     = rem_sh >= {1'b0, dv_d_q[g-1]};
    assign rem_n  = ge ? (rem_sh - {1'b0, dv_d_q[g-1]}) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[g] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[g] <= dv_vld_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_side_q[g] <= dv_side_q[g-1];
        dv_rem_q[g]  <= rem_n[31:0];
        dv_quo_q[g]  <= dv_quo_q[g-1] | (31'(ge) << J);
        dv_d_q[g]    <= dv_d_q[g-1];
      end
    end
  end

  // Stage S: mirror for negative inputs
  logic        s_vld_q;
  swu_side_t   s_side_q;
  logic [30:0] s_sig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (en_i) begin
      s_vld_q <= dv_vld_q[DIV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_side_q <= dv_side_q[DIV_N];
      s_sig_q  <= dv_side_q[DIV_N].x[15] ? (ONE_Q30 - dv_quo_q[DIV_N]) : dv_quo_q[DIV_N];
    end
  end

  assign valid_o = s_vld_q;
  assign side_o  = s_side_q;
  assign sig_o   = s_sig_q;

endmodule
